FILE: src/api_frame_receiver_checksum_assert.svh
// Assertion macros for the frame receiver.
// Each macro checks under the block clock and stays quiet while reset is high.
`ifndef API_FRAME_RECEIVER_CHECKSUM_ASSERT_SVH
`define API_FRAME_RECEIVER_CHECKSUM_ASSERT_SVH

// Same-cycle implication
`define AFRC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define AFRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/afrc_pkg.sv
`default_nettype none
package afrc_pkg;

  localparam logic [7:0] START_BYTE = 8'h7E;
  localparam logic [7:0] SUM_TARGET = 8'hFF;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_RX_FRAME_TYPE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_OFFSET     = 1'b1;

  localparam logic [7:0]  RST_FRAME_TYPE = 8'd144;
  localparam logic [15:0] RST_ID_OFFSET  = 16'd12;

  // Parser phase
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN_HI  = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK   = 3'd4
  } phase_t;

  // Result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_GOOD = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;

  // One result word
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic [15:0] byte_index;
    logic [7:0]  frame_type;
    logic [15:0] frame_length;
    logic        ids_valid;
    logic [7:0]  aircraft_id;
    logic [7:0]  msg_id;
  } res_t;

endpackage
`default_nettype wire

FILE: src/api_frame_receiver_checksum.sv
// API frame receiver with 8-bit checksum.
// Input channel: one received byte per word on rx_byte, handed over with
// in_valid; the block holds it off with in_stall. Output channel: one result
// word (payload byte with its index, or end of frame with checksum status,
// frame type, length and ids) on out_valid, held off by out_stall.
// Header bytes and bytes seen while hunting for 0x7E give no result.
// Configuration: cfg_we writes cfg_data into the register picked by
// cfg_index (0 frame type to match, 1 payload offset of the aircraft id).
// Each result is registered before it appears on the outputs.
// Throughput: one byte every cycle while in_stall is low; the parser state
// updates in the cycle a byte is taken, and the output register plus a
// one-word skid register hold a result while the receiver stalls.
// With the output stalled and both registers full, in_stall goes high until
// the receiver takes a word. Reset clears the parser to hunting, empties the
// output registers and restores the configuration defaults (frame type 144,
// id offset 12).
`default_nettype none
`include "api_frame_receiver_checksum_assert.svh"
module api_frame_receiver_checksum
  import afrc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           rx_byte,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                kind,
  output logic [7:0]                byte_value,
  output logic [15:0]               byte_index,
  output logic [7:0]                frame_type,
  output logic [15:0]               frame_length,
  output logic                      ids_valid,
  output logic [7:0]                aircraft_id,
  output logic [7:0]                msg_id
);

  logic [7:0]  cfg_frame_type;
  logic [15:0] cfg_id_offset;

  phase_t      phase, phase_next;
  logic [15:0] declared_length, declared_length_next;
  logic [15:0] bytes_seen, bytes_seen_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  captured_type, captured_type_next;
  logic [7:0]  captured_aircraft, captured_aircraft_next;
  logic [7:0]  captured_message, captured_message_next;

  logic        in_acc;
  logic        res_valid;
  res_t        res;
  logic        out_pop;
  res_t        out_word;
  logic        skid_valid;
  res_t        skid_word;

  logic [16:0] idx_inc;
  logic [16:0] off_inc;
  logic [16:0] off_plus2;
  logic [7:0]  chk_sum;
  logic        chk_good;
  logic        ids_ok;

  assign in_stall = skid_valid;
  assign in_acc   = in_valid && !in_stall;
  assign out_pop  = out_valid && !out_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_frame_type <= RST_FRAME_TYPE;
      cfg_id_offset  <= RST_ID_OFFSET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RX_FRAME_TYPE: cfg_frame_type <= cfg_data[7:0];
        CFG_ID_OFFSET:     cfg_id_offset  <= cfg_data;
      endcase
    end
  end

  // Shared arithmetic
  assign idx_inc   = {1'b0, bytes_seen} + 17'd1;
  assign off_inc   = {1'b0, cfg_id_offset} + 17'd1;
  assign off_plus2 = {1'b0, cfg_id_offset} + 17'd2;
  assign chk_sum   = rx_byte + running_sum;
  assign chk_good  = (chk_sum == SUM_TARGET);
  // zero length never fits since id_offset + 2 is at least 2
  assign ids_ok    = chk_good && ({1'b0, declared_length} >= off_plus2) &&
                     (captured_type == cfg_frame_type);

  // Next phase
  always_comb begin
    phase_next = phase;
    if (in_acc) begin
      unique case (phase)
        PH_HUNT:    phase_next = (rx_byte == START_BYTE) ? PH_LEN_HI : PH_HUNT;
        PH_LEN_HI:  phase_next = PH_LEN_LO;
        PH_LEN_LO:  phase_next = ({declared_length[15:8], rx_byte} == 16'd0) ?
                                 PH_CHECK : PH_PAYLOAD;
        PH_PAYLOAD: phase_next = (idx_inc >= {1'b0, declared_length}) ?
                                 PH_CHECK : PH_PAYLOAD;
        PH_CHECK:   phase_next = PH_HUNT;
        default:    phase_next = PH_HUNT;
      endcase
    end
  end

  // Frame datapath and result word
  always_comb begin
    declared_length_next   = declared_length;
    bytes_seen_next        = bytes_seen;
    running_sum_next       = running_sum;
    captured_type_next     = captured_type;
    captured_aircraft_next = captured_aircraft;
    captured_message_next  = captured_message;
    res_valid              = 1'b0;
    res                    = '0;
    if (in_acc) begin
      unique case (phase)
        PH_LEN_HI: begin
          declared_length_next = {rx_byte, 8'h00};
        end
        PH_LEN_LO: begin
          declared_length_next   = {declared_length[15:8], rx_byte};
          bytes_seen_next        = 16'd0;
          running_sum_next       = 8'd0;
          captured_type_next     = 8'd0;
          captured_aircraft_next = 8'd0;
          captured_message_next  = 8'd0;
        end
        PH_PAYLOAD: begin
          if (bytes_seen == 16'd0) captured_type_next = rx_byte;
          if (bytes_seen == cfg_id_offset) captured_aircraft_next = rx_byte;
          if ({1'b0, bytes_seen} == off_inc) captured_message_next = rx_byte;
          running_sum_next = running_sum + rx_byte;
          bytes_seen_next  = idx_inc[15:0];
          res_valid        = 1'b1;
          res.kind         = KIND_BYTE;
          res.byte_value   = rx_byte;
          res.byte_index   = bytes_seen;
        end
        PH_CHECK: begin
          res_valid        = 1'b1;
          res.kind         = chk_good ? KIND_GOOD : KIND_BAD;
          res.byte_value   = rx_byte;
          res.frame_type   = captured_type;
          res.frame_length = declared_length;
          res.ids_valid    = ids_ok;
          res.aircraft_id  = ids_ok ? captured_aircraft : 8'd0;
          res.msg_id       = ids_ok ? captured_message : 8'd0;
        end
        default: begin
        end
      endcase
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HUNT;
      declared_length   <= 16'd0;
      bytes_seen        <= 16'd0;
      running_sum       <= 8'd0;
      captured_type     <= 8'd0;
      captured_aircraft <= 8'd0;
      captured_message  <= 8'd0;
    end else begin
      phase             <= phase_next;
      declared_length   <= declared_length_next;
      bytes_seen        <= bytes_seen_next;
      running_sum       <= running_sum_next;
      captured_type     <= captured_type_next;
      captured_aircraft <= captured_aircraft_next;
      captured_message  <= captured_message_next;
    end
  end

  // Output register with one-word skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_pop) begin
        out_word   <= skid_word;
        skid_valid <= 1'b0;
      end
    end else begin
      if (res_valid && (!out_valid || out_pop)) begin
        out_word <= res;
      end else if (res_valid) begin
        skid_word  <= res;
        skid_valid <= 1'b1;
      end
      out_valid <= res_valid || (out_valid && !out_pop);
    end
  end

  assign kind         = out_word.kind;
  assign byte_value   = out_word.byte_value;
  assign byte_index   = out_word.byte_index;
  assign frame_type   = out_word.frame_type;
  assign frame_length = out_word.frame_length;
  assign ids_valid    = out_word.ids_valid;
  assign aircraft_id  = out_word.aircraft_id;
  assign msg_id       = out_word.msg_id;

  // Checks
  `AFRC_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid,
                   "skid full with output empty")
  `AFRC_ASSERT_NOW(a_count_in_range, phase == PH_PAYLOAD,
                   bytes_seen < declared_length, "payload count past length")
  `AFRC_ASSERT_NEXT(a_payload_result, in_acc && phase == PH_PAYLOAD, out_valid,
                    "payload byte gave no result")
  `AFRC_ASSERT_NEXT(a_check_ends, in_acc && phase == PH_CHECK, phase == PH_HUNT,
                    "no hunt after checksum")

endmodule
`default_nettype wire
